// ===== src/nmea_rmc_pkg.sv =====
package nmea_rmc_pkg;

  localparam int FIELD_CHARS_DEF = 16;

  localparam int PREFIX_LEN = 6;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_FIX_OK = 8'h41;

  localparam logic [1:0] CODE_TIME = 2'd0;
  localparam logic [1:0] CODE_LAT = 2'd1;
  localparam logic [1:0] CODE_LON = 2'd2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [2:0] FLD_TIME = 3'd1;
  localparam logic [2:0] FLD_STATUS = 3'd2;
  localparam logic [2:0] FLD_LAT = 3'd3;
  localparam logic [2:0] FLD_LAT_DIR = 3'd4;
  localparam logic [2:0] FLD_LON = 3'd5;
  localparam logic [2:0] FLD_LON_DIR = 3'd6;
  localparam logic [2:0] FLD_MAX = 3'd7;

  // "$GPRMC"
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h24;
      3'd1: ch = 8'h47;
      3'd2: ch = 8'h50;
      3'd3: ch = 8'h52;
      3'd4: ch = 8'h4D;
      3'd5: ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/nmea_rmc_field_parser_core.sv =====
// NMEA RMC sentence parser, one sentence character per input beat.
// Input channel: in_byte/in_last with in_valid/in_stall; in_last marks the
// final character of a sentence. Result channel: out_* fields with
// out_valid/out_stall. A character of the time, latitude or longitude field
// of a "$GPRMC" sentence gives a character beat, for up to FIELD_CHARS per
// field; the final character is followed by a summary beat. out_last marks
// the last beat caused by one input character.
// A result passes through the input register and then the result queue
// before it is offered; while the queue is too full, the character waits in
// the input register.
// Throughput: one character per cycle while the result queue has room. A final
// character that also gives a character beat gives two result beats; a
// 4-entry result queue absorbs this, and input is stalled while it has fewer
// than two free slots. A stalled output holds its beat; the queue keeps filling
// until the input side stalls.
// Reset (rst_n low, synchronous) empties the queue, clears the sentence
// state and the stored fix flag and direction letters.
module nmea_rmc_field_parser_core
  import nmea_rmc_pkg::*;
#(
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [1:0] out_field_code,
  output logic [3:0] out_char_pos,
  output logic [7:0] out_char_value,
  output logic       out_is_rmc,
  output logic       out_fix_valid,
  output logic [7:0] out_lat_dir,
  output logic [7:0] out_lon_dir,
  output logic       out_field_overflow,
  output logic       out_last
);

  localparam int CW = $clog2(FIELD_CHARS + 1);
  localparam logic [CW-1:0] CC_MAX = CW'(FIELD_CHARS);

  typedef struct packed {
    logic       kind;
    logic [1:0] code;
    logic [3:0] pos;
    logic [7:0] val;
    logic       rmc;
    logic       fix;
    logic [7:0] lat;
    logic [7:0] lon;
    logic       ovf;
    logic       last;
  } res_t;

  // input register
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // sentence state
  logic [2:0]    prefix_pos_r, prefix_pos_nxt;
  logic          prefix_ok_r, prefix_ok_nxt;
  logic [2:0]    field_index_r, field_index_nxt;
  logic [CW-1:0] char_count_r, char_count_nxt;
  logic          overflow_r, overflow_nxt;
  logic          fix_flag_r, fix_flag_nxt;
  logic [7:0]    lat_letter_r, lat_letter_nxt;
  logic [7:0]    lon_letter_r, lon_letter_nxt;

  // result queue
  res_t       q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  logic       fire, pop;
  logic       emit_char;
  logic [1:0] char_code;
  logic [1:0] push_n;
  res_t       char_res, sum_res, res0, res1;
  logic       rmc;

  assign fire = in_vld_r && (cnt_r <= 3'd2);
  assign in_stall = in_vld_r && !fire;
  assign out_valid = (cnt_r != 3'd0);
  assign pop = out_valid && !out_stall;

  always_comb begin
    prefix_pos_nxt = prefix_pos_r;
    prefix_ok_nxt = prefix_ok_r;
    field_index_nxt = field_index_r;
    char_count_nxt = char_count_r;
    overflow_nxt = overflow_r;
    fix_flag_nxt = fix_flag_r;
    lat_letter_nxt = lat_letter_r;
    lon_letter_nxt = lon_letter_r;
    emit_char = 1'b0;
    char_code = CODE_TIME;

    if (prefix_pos_r < 3'(PREFIX_LEN)) begin
      if (byte_r != prefix_char(prefix_pos_r)) begin
        prefix_ok_nxt = 1'b0;
      end
      prefix_pos_nxt = prefix_pos_r + 3'd1;
    end

    if (byte_r == CHAR_COMMA) begin
      if (field_index_r < FLD_MAX) begin
        field_index_nxt = field_index_r + 3'd1;
      end
      char_count_nxt = '0;
      if (prefix_ok_nxt) begin
        if (field_index_nxt == FLD_STATUS) fix_flag_nxt = 1'b0;
        if (field_index_nxt == FLD_LAT_DIR) lat_letter_nxt = 8'h00;
        if (field_index_nxt == FLD_LON_DIR) lon_letter_nxt = 8'h00;
      end
    end else if (prefix_ok_nxt && field_index_r != 3'd0) begin
      if (field_index_r == FLD_TIME || field_index_r == FLD_LAT ||
          field_index_r == FLD_LON) begin
        char_code = (field_index_r == FLD_TIME) ? CODE_TIME :
                    (field_index_r == FLD_LAT) ? CODE_LAT : CODE_LON;
        if (char_count_r < CC_MAX) begin
          emit_char = 1'b1;
        end else begin
          overflow_nxt = 1'b1;
        end
      end else if (char_count_r == '0) begin
        if (field_index_r == FLD_STATUS) fix_flag_nxt = (byte_r == CHAR_FIX_OK);
        if (field_index_r == FLD_LAT_DIR) lat_letter_nxt = byte_r;
        if (field_index_r == FLD_LON_DIR) lon_letter_nxt = byte_r;
      end
      if (char_count_r < CC_MAX) begin
        char_count_nxt = char_count_r + CW'(1);
      end
    end

    rmc = prefix_ok_nxt && (prefix_pos_nxt >= 3'(PREFIX_LEN));

    char_res = '0;
    char_res.kind = KIND_CHAR;
    char_res.code = char_code;
    char_res.pos = 4'(char_count_r);
    char_res.val = byte_r;
    char_res.last = !last_r;

    sum_res = '0;
    sum_res.kind = KIND_SUMMARY;
    sum_res.rmc = rmc;
    sum_res.fix = rmc && fix_flag_nxt;
    sum_res.lat = lat_letter_nxt;
    sum_res.lon = lon_letter_nxt;
    sum_res.ovf = overflow_nxt;
    sum_res.last = 1'b1;

    res0 = emit_char ? char_res : sum_res;
    res1 = sum_res;
    push_n = 2'(emit_char) + 2'(last_r);

    if (last_r) begin
      prefix_pos_nxt = '0;
      prefix_ok_nxt = 1'b1;
      field_index_nxt = '0;
      char_count_nxt = '0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      prefix_pos_r <= '0;
      prefix_ok_r <= 1'b1;
      field_index_r <= '0;
      char_count_r <= '0;
      overflow_r <= 1'b0;
      fix_flag_r <= 1'b0;
      lat_letter_r <= '0;
      lon_letter_r <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        prefix_pos_r <= prefix_pos_nxt;
        prefix_ok_r <= prefix_ok_nxt;
        field_index_r <= field_index_nxt;
        char_count_r <= char_count_nxt;
        overflow_r <= overflow_nxt;
        fix_flag_r <= fix_flag_nxt;
        lat_letter_r <= lat_letter_nxt;
        lon_letter_r <= lon_letter_nxt;
        wr_ptr_r <= wr_ptr_r + push_n;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + (fire ? 3'(push_n) : 3'd0) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (fire && push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (fire && push_n == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  assign out_kind = q_r[rd_ptr_r].kind;
  assign out_field_code = q_r[rd_ptr_r].code;
  assign out_char_pos = q_r[rd_ptr_r].pos;
  assign out_char_value = q_r[rd_ptr_r].val;
  assign out_is_rmc = q_r[rd_ptr_r].rmc;
  assign out_fix_valid = q_r[rd_ptr_r].fix;
  assign out_lat_dir = q_r[rd_ptr_r].lat;
  assign out_lon_dir = q_r[rd_ptr_r].lon;
  assign out_field_overflow = q_r[rd_ptr_r].ovf;
  assign out_last = q_r[rd_ptr_r].last;

endmodule

// ===== src/nmea_rmc_chk.sv =====
module nmea_rmc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [1:0] out_field_code,
  input logic [3:0] out_char_pos,
  input logic [7:0] out_char_value,
  input logic       out_is_rmc,
  input logic       out_fix_valid,
  input logic [7:0] out_lat_dir,
  input logic [7:0] out_lon_dir,
  input logic       out_field_overflow,
  input logic       out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_last)
      && $stable(out_char_value) && $stable(out_char_pos))
    else $error("stalled result beat changed");

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last && out_field_code == 2'd0 && out_char_value == 8'h00)
    else $error("malformed summary beat");

  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_is_rmc && !out_fix_valid && !out_field_overflow
      && out_lat_dir == 8'h00 && out_lon_dir == 8'h00 && out_field_code != 2'd3)
    else $error("malformed character beat");

  a_fix_needs_rmc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_valid |-> out_is_rmc)
    else $error("fix reported for non-RMC sentence");

endmodule

bind nmea_rmc_field_parser_core nmea_rmc_chk u_nmea_rmc_chk (.*);

// ===== tb/nmea_rmc_field_parser_core_tb.sv =====
`timescale 1ns / 100ps
module nmea_rmc_field_parser_core_tb;
  import nmea_rmc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int CHAR_BUDGET = 1750;
  localparam logic [47:0] RMC_TAG = "$GPRMC";

  typedef struct packed {
    logic       kind;
    logic [1:0] code;
    logic [3:0] pos;
    logic [7:0] value;
    logic       rmc;
    logic       fix;
    logic [7:0] lat;
    logic [7:0] lon;
    logic       ovf;
    logic       last;
  } rmc_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    rmc_beat_t  want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [1:0] out_field_code;
  logic [3:0] out_char_pos;
  logic [7:0] out_char_value;
  logic       out_is_rmc;
  logic       out_fix_valid;
  logic [7:0] out_lat_dir;
  logic [7:0] out_lon_dir;
  logic       out_field_overflow;
  logic       out_last;

  rmc_beat_t  expected_beats[$];
  dir_row_t   dir_rows[$];
  logic [7:0] line_q[$];

  // sentence parser state as predicted
  logic [2:0] tag_pos = '0;
  logic       tag_ok = 1'b1;
  logic [2:0] fld_num = '0;
  logic [4:0] fld_len = '0;
  logic       long_seen = 1'b0;
  logic       fix_st = 1'b0;
  logic [7:0] lat_st = '0;
  logic [7:0] lon_st = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int quiet = 0;
  int n_chars = 0;
  int n_lines = 0;
  int n_beats = 0;
  int n_summ = 0;

  nmea_rmc_field_parser_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_field_code     (out_field_code),
    .out_char_pos       (out_char_pos),
    .out_char_value     (out_char_value),
    .out_is_rmc         (out_is_rmc),
    .out_fix_valid      (out_fix_valid),
    .out_lat_dir        (out_lat_dir),
    .out_lon_dir        (out_lon_dir),
    .out_field_overflow (out_field_overflow),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic parse_char(input logic [7:0] ch, input logic fin, input bit post);
    rmc_beat_t  char_r;
    rmc_beat_t  summ_r;
    logic [1:0] code;
    bit         capt;
    bit         have_char;
    have_char = 1'b0;
    char_r = '0;
    summ_r = '0;
    if (tag_pos < PREFIX_LEN) begin
      if (ch != RMC_TAG[47 - 8 * tag_pos -: 8]) tag_ok = 1'b0;
      tag_pos++;
    end
    if (ch == CHAR_COMMA) begin
      if (fld_num < FLD_MAX) fld_num++;
      fld_len = '0;
      if (tag_ok) begin
        if (fld_num == FLD_STATUS) fix_st = 1'b0;
        if (fld_num == FLD_LAT_DIR) lat_st = '0;
        if (fld_num == FLD_LON_DIR) lon_st = '0;
      end
    end else if (tag_ok && fld_num != 0) begin
      capt = 1'b1;
      code = CODE_TIME;
      case (fld_num)
        FLD_TIME: code = CODE_TIME;
        FLD_LAT: code = CODE_LAT;
        FLD_LON: code = CODE_LON;
        default: capt = 1'b0;
      endcase
      if (!capt && fld_len == 0) begin
        if (fld_num == FLD_STATUS) fix_st = (ch == CHAR_FIX_OK);
        if (fld_num == FLD_LAT_DIR) lat_st = ch;
        if (fld_num == FLD_LON_DIR) lon_st = ch;
      end
      if (capt) begin
        if (fld_len < FIELD_CHARS_DEF) begin
          have_char = 1'b1;
          char_r.kind = KIND_CHAR;
          char_r.code = code;
          char_r.pos = fld_len[3:0];
          char_r.value = ch;
        end else begin
          long_seen = 1'b1;
        end
      end
      if (fld_len < FIELD_CHARS_DEF) fld_len++;
    end
    if (fin) begin
      summ_r.kind = KIND_SUMMARY;
      summ_r.rmc = tag_ok && (tag_pos >= PREFIX_LEN);
      summ_r.fix = summ_r.rmc & fix_st;
      summ_r.lat = lat_st;
      summ_r.lon = lon_st;
      summ_r.ovf = long_seen;
      summ_r.last = 1'b1;
      tag_pos = '0;
      tag_ok = 1'b1;
      fld_num = '0;
      fld_len = '0;
      long_seen = 1'b0;
    end else begin
      char_r.last = 1'b1;
    end
    if (post) begin
      if (have_char) expected_beats.push_back(char_r);
      if (fin) expected_beats.push_back(summ_r);
    end
  endtask

  function automatic void chk(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : mon
    rmc_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_beats++;
        if (expected_beats.size() == 0) begin
          $error("result beat with no expected beat pending");
          err_cnt++;
        end else begin
          want = expected_beats.pop_front();
          if (want.kind == KIND_SUMMARY) n_summ++;
          chk("out_kind", want.kind, out_kind);
          chk("out_field_code", want.code, out_field_code);
          chk("out_char_pos", want.pos, out_char_pos);
          chk("out_char_value", want.value, out_char_value);
          chk("out_is_rmc", want.rmc, out_is_rmc);
          chk("out_fix_valid", want.fix, out_fix_valid);
          chk("out_lat_dir", want.lat, out_lat_dir);
          chk("out_lon_dir", want.lon, out_lon_dir);
          chk("out_field_overflow", want.ovf, out_field_overflow);
          chk("out_last", want.last, out_last);
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] ch, input logic fin, input bit typed,
                           input rmc_beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= ch;
    in_last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_chars++;
    if (typed) begin
      parse_char(ch, fin, 1'b0);
      expected_beats.push_back(want);
    end else begin
      parse_char(ch, fin, 1'b1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic add_text(input string s, input bit fin_end);
    dir_row_t row;
    for (int i = 0; i < s.len(); i++) begin
      row = '0;
      row.ch = s.getc(i);
      row.fin = fin_end && (i == s.len() - 1);
      dir_rows.push_back(row);
    end
  endtask

  initial begin : main
    rmc_beat_t w;
    dir_row_t  row;
    bit        good;
    int        ph, sel, nf, len, f, k, r;
    logic [7:0] ch;
    int        idle_set[4];
    int        stall_set[4];
    idle_set = '{0, 79, 0, 20};
    stall_set = '{0, 0, 79, 20};

    // short non-matching sentence right after reset
    w = '0;
    w.kind = KIND_SUMMARY;
    w.last = 1'b1;
    row = '0;
    row.ch = "X";
    row.fin = 1'b1;
    row.typed = 1'b1;
    row.want = w;
    dir_rows.push_back(row);
    // full sentence, extreme bytes in time and latitude, empty lat direction
    add_text("$GPRMC,", 1'b0);
    row = '0;
    row.ch = 8'hFF;
    dir_rows.push_back(row);
    add_text(",A,", 1'b0);
    row.ch = 8'h00;
    dir_rows.push_back(row);
    add_text(",,3,E", 1'b1);
    // empty time and status, ends inside latitude, trailing fields missing
    add_text("$GPRMC,,,7", 1'b1);
    // non-matching sentence reports the kept letters
    w.lon = "E";
    row = '0;
    row.ch = 8'hFF;
    row.fin = 1'b1;
    row.typed = 1'b1;
    row.want = w;
    dir_rows.push_back(row);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      while (n_chars < CHAR_BUDGET * (ph + 1) / 4) begin
        line_q.delete();
        sel = $urandom_range(99);
        good = (sel < 70);
        if (sel < 88) begin
          for (k = 0; k < PREFIX_LEN; k++) line_q.push_back(RMC_TAG[47 - 8 * k -: 8]);
          if (!good) begin
            if (sel < 79) begin
              line_q[$urandom_range(PREFIX_LEN - 1)] = 8'($urandom_range(255));
            end else begin
              len = $urandom_range(1, PREFIX_LEN - 1);
              while (line_q.size() > len) void'(line_q.pop_back());
            end
          end
          nf = $urandom_range(9);
          for (f = 1; f <= nf; f++) begin
            line_q.push_back(CHAR_COMMA);
            if ($urandom_range(15) == 0)
              len = $urandom_range(FIELD_CHARS_DEF + 4, FIELD_CHARS_DEF - 2);
            else
              len = $urandom_range(6);
            for (k = 0; k < len; k++) begin
              r = $urandom_range(15);
              if (r == 0) ch = 8'($urandom_range(255));
              else if (f == FLD_STATUS) ch = r[0] ? CHAR_FIX_OK : "V";
              else if (f == FLD_LAT_DIR) ch = r[0] ? "N" : "S";
              else if (f == FLD_LON_DIR) ch = r[0] ? "E" : "W";
              else if (r == 1) ch = ".";
              else ch = 8'h30 + 8'($urandom_range(9));
              line_q.push_back(ch);
            end
          end
        end else begin
          len = $urandom_range(1, 12);
          repeat (len) line_q.push_back(8'($urandom_range(255)));
        end
        foreach (line_q[i]) send_beat(line_q[i], i == line_q.size() - 1, 1'b0, '0);
        n_lines++;
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d characters: the directed table and %0d random sentences,",
             n_chars, n_lines);
    $display("under four idle/stall mixes; %0d result beats checked, %0d summaries.",
             n_beats, n_summ);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
